// ===== hdl/bibs_pkg.sv =====
// Shared types, constants and the opcode length table for the bytecode boundary scanner.
package bibs_pkg;

    // Longest jump table (in bytes) that a switch may carry
    localparam int MAX_CODE_BYTES = 65535;
    // Width of the operand/pad/table skip counter
    localparam int SKIP_W = $clog2(MAX_CODE_BYTES + 1);
    // Largest tableswitch entry count and lookupswitch pair count that fit
    localparam logic [31:0] TS_MAX_ENTRIES = 32'(MAX_CODE_BYTES / 4);
    localparam logic [30:0] LS_MAX_PAIRS   = 31'(MAX_CODE_BYTES / 8);

    // Opcodes with special handling
    localparam logic [7:0] OP_IINC         = 8'd132;
    localparam logic [7:0] OP_RET          = 8'd169;
    localparam logic [7:0] OP_TABLESWITCH  = 8'd170;
    localparam logic [7:0] OP_LOOKUPSWITCH = 8'd171;
    localparam logic [7:0] OP_WIDE         = 8'd196;

    typedef enum logic [3:0] {
        PH_OPCODE,
        PH_SKIP,
        PH_WIDE,
        PH_PAD_TS,
        PH_PAD_LS,
        PH_TS_DEF,
        PH_TS_LOW,
        PH_TS_HIGH,
        PH_LS_DEF,
        PH_LS_NPAIRS,
        PH_FAULT
    } phase_t;

    typedef enum logic [2:0] {
        ST_RUN        = 3'd0,
        ST_ACCEPT     = 3'd1,
        ST_BAD_OP     = 3'd2,
        ST_BAD_WIDE   = 3'd3,
        ST_LENGTH     = 3'd4,
        ST_BAD_SWITCH = 3'd5
    } status_t;

    // One result transaction as it travels from the parser to the result register
    typedef struct packed {
        logic    starts;
        status_t status;
    } result_t;

    // Length of a fixed-length instruction including its opcode; 0 if invalid
    function automatic logic [2:0] op_length(input logic [7:0] op);
        logic [2:0] n;
        case (op) inside
            [8'd0:8'd15]:               n = 3'd1;
            8'd16, 8'd18:               n = 3'd2;
            8'd17, 8'd19, 8'd20:        n = 3'd3;
            [8'd21:8'd25]:              n = 3'd2;
            [8'd26:8'd53]:              n = 3'd1;
            [8'd54:8'd58]:              n = 3'd2;
            [8'd59:8'd131]:             n = 3'd1;
            8'd132:                     n = 3'd3;
            [8'd133:8'd152]:            n = 3'd1;
            [8'd153:8'd168]:            n = 3'd3;
            8'd169:                     n = 3'd2;
            [8'd172:8'd177]:            n = 3'd1;
            [8'd178:8'd184]:            n = 3'd3;
            8'd185:                     n = 3'd5;
            8'd187:                     n = 3'd3;
            8'd188:                     n = 3'd2;
            8'd189:                     n = 3'd3;
            [8'd190:8'd191]:            n = 3'd1;
            [8'd192:8'd193]:            n = 3'd3;
            [8'd194:8'd195]:            n = 3'd1;
            8'd197:                     n = 3'd4;
            [8'd198:8'd199]:            n = 3'd3;
            [8'd200:8'd201]:            n = 3'd5;
            default:                    n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

// ===== hdl/bytecode_instruction_boundary_scanner.sv =====
// Top level of the bytecode instruction boundary scanner.
//
//   channel  direction  payload                          handshake
//   s_       in         code_byte[7:0], last_byte        s_valid / s_ready
//   m_       out        starts_instruction, status[2:0]  m_valid / m_ready
//
// One byte per cycle sustained while the sink keeps m_ready high; each result is
// offered after its byte passes through the input register, then the result register.
// Each byte is decoded combinationally between the input register and the
// result register, using the opcode length table and the parse state.
// aresetn is synchronous and active low; it returns the parser to the start
// of a method. A stalled sink holds the result; the input register still
// drains into the result register whenever that register is freed.
module bytecode_instruction_boundary_scanner (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_code_byte,
    input  logic       s_last_byte,
    input  logic       s_valid,
    output logic       s_ready,
    output logic       m_starts_instruction,
    output logic [2:0] m_status,
    output logic       m_valid,
    input  logic       m_ready
);

    logic              in_valid;
    logic [7:0]        code_byte;
    logic              last_byte;
    logic              can_load;
    logic              step;
    bibs_pkg::result_t result;

    // Move a byte through the parser when the result register is free
    assign step = in_valid && can_load;

    bibs_in_stage u_in (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_code_byte (s_code_byte),
        .s_last_byte (s_last_byte),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .take        (step),
        .in_valid    (in_valid),
        .code_byte   (code_byte),
        .last_byte   (last_byte)
    );

    bibs_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .code_byte (code_byte),
        .last_byte (last_byte),
        .result    (result)
    );

    bibs_out_stage u_out (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .load                 (step),
        .result               (result),
        .can_load             (can_load),
        .m_starts_instruction (m_starts_instruction),
        .m_status             (m_status),
        .m_valid              (m_valid),
        .m_ready              (m_ready)
    );

endmodule

// ===== hdl/bibs_in_stage.sv =====
// Input register: holds one byte transaction until the parser consumes it.
module bibs_in_stage (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic [7:0] s_code_byte,
    input  logic       s_last_byte,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic       take,
    output logic       in_valid,
    output logic [7:0] code_byte,
    output logic       last_byte
);

    logic       valid_reg;
    logic       valid_next;
    logic [7:0] byte_reg;
    logic       last_reg;

    // Accept whenever the slot is empty or drains this cycle
    assign s_ready = !valid_reg || take;

    always_comb begin
        valid_next = valid_reg;
        if (s_valid && s_ready) begin
            valid_next = 1'b1;
        end else if (take) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Load payload on each accepted transaction
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            byte_reg <= s_code_byte;
            last_reg <= s_last_byte;
        end
    end

    assign in_valid  = valid_reg;
    assign code_byte = byte_reg;
    assign last_byte = last_reg;

endmodule

// ===== hdl/bibs_parse.sv =====
// Parse state and combinational next-state logic for one bytecode byte.
module bibs_parse (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic [7:0]           code_byte,
    input  logic                 last_byte,
    output bibs_pkg::result_t    result
);

    localparam int SW = bibs_pkg::SKIP_W;

    bibs_pkg::phase_t  phase_reg, phase_next;
    logic [1:0]        pos_reg, pos_next;
    logic [SW-1:0]     skip_reg, skip_next;
    logic [31:0]       word_reg, word_next;
    logic [31:0]       low_reg, low_next;
    logic [1:0]        biw_reg, biw_next;
    bibs_pkg::status_t fault_reg, fault_next;

    logic [2:0]        op_len;
    logic [1:0]        pad;
    logic [31:0]       word_shift;
    logic [32:0]       ts_diff;
    logic              ts_neg;
    logic              ts_big;
    logic [SW-3:0]     ts_cnt;
    logic              ls_big;
    logic              starts;
    bibs_pkg::status_t status;

    assign op_len     = bibs_pkg::op_length(code_byte);
    // Padding to the next multiple of four after the opcode byte
    assign pad        = ~pos_reg;
    assign word_shift = {word_reg[23:0], code_byte};

    // Switch bound arithmetic on the word completing this cycle
    assign ts_diff = {word_shift[31], word_shift} - {low_reg[31], low_reg};
    assign ts_neg  = ts_diff[32];
    assign ts_big  = ts_diff[31:0] >= bibs_pkg::TS_MAX_ENTRIES;
    assign ts_cnt  = ts_diff[SW-3:0] + 1'b1;
    assign ls_big  = word_shift[30:0] > bibs_pkg::LS_MAX_PAIRS;

    // Next parse state
    always_comb begin
        phase_next = phase_reg;
        pos_next   = pos_reg + 2'd1;
        skip_next  = skip_reg;
        word_next  = word_reg;
        low_next   = low_reg;
        biw_next   = biw_reg;
        fault_next = fault_reg;
        starts     = 1'b0;
        case (phase_reg)
            bibs_pkg::PH_OPCODE: begin
                if (code_byte == bibs_pkg::OP_WIDE) begin
                    starts     = 1'b1;
                    phase_next = bibs_pkg::PH_WIDE;
                end else if (code_byte == bibs_pkg::OP_TABLESWITCH ||
                             code_byte == bibs_pkg::OP_LOOKUPSWITCH) begin
                    starts    = 1'b1;
                    biw_next  = 2'd0;
                    word_next = 32'd0;
                    if (pad != 2'd0) begin
                        skip_next  = SW'(pad);
                        phase_next = (code_byte == bibs_pkg::OP_TABLESWITCH) ?
                                     bibs_pkg::PH_PAD_TS : bibs_pkg::PH_PAD_LS;
                    end else begin
                        phase_next = (code_byte == bibs_pkg::OP_TABLESWITCH) ?
                                     bibs_pkg::PH_TS_DEF : bibs_pkg::PH_LS_DEF;
                    end
                end else if (op_len == 3'd0) begin
                    fault_next = bibs_pkg::ST_BAD_OP;
                    phase_next = bibs_pkg::PH_FAULT;
                    skip_next  = '0;
                end else begin
                    starts = 1'b1;
                    if (op_len > 3'd1) begin
                        skip_next  = SW'(op_len - 3'd1);
                        phase_next = bibs_pkg::PH_SKIP;
                    end
                end
            end
            bibs_pkg::PH_SKIP, bibs_pkg::PH_PAD_TS, bibs_pkg::PH_PAD_LS: begin
                // Count down operand, pad or table bytes
                skip_next = skip_reg - 1'b1;
                if (skip_reg == SW'(1)) begin
                    if (phase_reg == bibs_pkg::PH_PAD_TS) begin
                        phase_next = bibs_pkg::PH_TS_DEF;
                    end else if (phase_reg == bibs_pkg::PH_PAD_LS) begin
                        phase_next = bibs_pkg::PH_LS_DEF;
                    end else begin
                        phase_next = bibs_pkg::PH_OPCODE;
                    end
                end
            end
            bibs_pkg::PH_WIDE: begin
                if (code_byte inside {[8'd21:8'd25], [8'd54:8'd58], bibs_pkg::OP_RET}) begin
                    skip_next  = SW'(2);
                    phase_next = bibs_pkg::PH_SKIP;
                end else if (code_byte == bibs_pkg::OP_IINC) begin
                    skip_next  = SW'(4);
                    phase_next = bibs_pkg::PH_SKIP;
                end else begin
                    fault_next = bibs_pkg::ST_BAD_WIDE;
                    phase_next = bibs_pkg::PH_FAULT;
                    skip_next  = '0;
                end
            end
            bibs_pkg::PH_TS_DEF, bibs_pkg::PH_TS_LOW, bibs_pkg::PH_TS_HIGH,
            bibs_pkg::PH_LS_DEF, bibs_pkg::PH_LS_NPAIRS: begin
                // Gather big-endian words and act on each completed one
                word_next = word_shift;
                if (biw_reg == 2'd3) begin
                    biw_next = 2'd0;
                    case (phase_reg)
                        bibs_pkg::PH_TS_DEF: phase_next = bibs_pkg::PH_TS_LOW;
                        bibs_pkg::PH_TS_LOW: begin
                            low_next   = word_shift;
                            phase_next = bibs_pkg::PH_TS_HIGH;
                        end
                        bibs_pkg::PH_TS_HIGH: begin
                            if (ts_neg || ts_big) begin
                                fault_next = bibs_pkg::ST_BAD_SWITCH;
                                phase_next = bibs_pkg::PH_FAULT;
                                skip_next  = '0;
                            end else begin
                                skip_next  = {ts_cnt, 2'b00};
                                phase_next = bibs_pkg::PH_SKIP;
                            end
                        end
                        bibs_pkg::PH_LS_DEF: phase_next = bibs_pkg::PH_LS_NPAIRS;
                        default: begin
                            if (word_shift[31] || ls_big) begin
                                fault_next = bibs_pkg::ST_BAD_SWITCH;
                                phase_next = bibs_pkg::PH_FAULT;
                                skip_next  = '0;
                            end else if (word_shift == 32'd0) begin
                                phase_next = bibs_pkg::PH_OPCODE;
                            end else begin
                                skip_next  = {word_shift[SW-4:0], 3'b000};
                                phase_next = bibs_pkg::PH_SKIP;
                            end
                        end
                    endcase
                end else begin
                    biw_next = biw_reg + 2'd1;
                end
            end
            default: begin
                // Fault: ignore bytes until the end of the method
            end
        endcase

        // Report status; the last byte closes the method
        if (last_byte) begin
            if (fault_next != bibs_pkg::ST_RUN) begin
                status = fault_next;
            end else if (phase_next == bibs_pkg::PH_OPCODE) begin
                status = bibs_pkg::ST_ACCEPT;
            end else begin
                status = bibs_pkg::ST_LENGTH;
            end
            phase_next = bibs_pkg::PH_OPCODE;
            pos_next   = 2'd0;
            skip_next  = '0;
            word_next  = 32'd0;
            low_next   = 32'd0;
            biw_next   = 2'd0;
            fault_next = bibs_pkg::ST_RUN;
        end else begin
            status = fault_next;
        end
    end

    assign result = '{starts: starts, status: status};

    // Advance state on each consumed byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= bibs_pkg::PH_OPCODE;
            pos_reg   <= 2'd0;
            skip_reg  <= '0;
            biw_reg   <= 2'd0;
            fault_reg <= bibs_pkg::ST_RUN;
        end else if (step) begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            skip_reg  <= skip_next;
            biw_reg   <= biw_next;
            fault_reg <= fault_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            word_reg <= 32'd0;
            low_reg  <= 32'd0;
        end else if (step) begin
            word_reg <= word_next;
            low_reg  <= low_next;
        end
    end

endmodule

// ===== hdl/bibs_out_stage.sv =====
// Result register: holds one result transaction until the sink takes it.
module bibs_out_stage (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              load,
    input  bibs_pkg::result_t result,
    output logic              can_load,
    output logic              m_starts_instruction,
    output logic [2:0]        m_status,
    output logic              m_valid,
    input  logic              m_ready
);

    logic              valid_reg;
    logic              valid_next;
    bibs_pkg::result_t data_reg;

    // Free when empty or being drained this cycle
    assign can_load = !valid_reg || m_ready;

    always_comb begin
        valid_next = valid_reg;
        if (load) begin
            valid_next = 1'b1;
        end else if (m_ready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= result;
        end
    end

    assign m_valid              = valid_reg;
    assign m_starts_instruction = data_reg.starts;
    assign m_status             = data_reg.status;

endmodule

// ===== hdl/bibs_checker.sv =====
// Port-level assertions for the boundary scanner and their bind.
module bibs_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_starts_instruction,
    input logic [2:0] m_status,
    input logic       m_valid,
    input logic       m_ready
);

    // Nothing is offered right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    // Hold a stalled result
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) &&
                                $stable(m_starts_instruction))
        else $error("stalled result changed");

    // Status stays within its defined codes
    a_status_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_status <= bibs_pkg::ST_BAD_SWITCH)
        else $error("undefined status code");

    // A faulting or post-fault byte never marks an instruction start
    a_fault_no_start: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == bibs_pkg::ST_BAD_OP || m_status == bibs_pkg::ST_BAD_WIDE ||
                    m_status == bibs_pkg::ST_BAD_SWITCH)
        |-> !m_starts_instruction)
        else $error("instruction start reported with a fault status");

    // With the result side empty the input side is always open
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input not ready with an empty result register");

endmodule

bind bytecode_instruction_boundary_scanner bibs_checker u_bibs_checker (
    .aclk                 (aclk),
    .aresetn              (aresetn),
    .s_valid              (s_valid),
    .s_ready              (s_ready),
    .m_starts_instruction (m_starts_instruction),
    .m_status             (m_status),
    .m_valid              (m_valid),
    .m_ready              (m_ready)
);
